@@ src/y2rq_pkg.sv @@
package y2rq_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned NORM_W     = 16;
  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned PROD_W     = 27;
  localparam int unsigned SUM_W      = 28;
  localparam int unsigned SCL_W      = 32;
  localparam int unsigned BIAS_W     = 34;
  localparam int unsigned QSH_W      = 18;

  // BT.601 full range, Q16
  localparam logic signed [17:0] COEF_RV = 18'sd91881;
  localparam logic signed [17:0] COEF_GU = 18'sd22554;
  localparam logic signed [17:0] COEF_GV = 18'sd46802;
  localparam logic signed [17:0] COEF_BU = 18'sd116130;

  localparam logic [CFG_IDX_W-1:0] REG_QUANT_MODE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUANT_GAIN = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_POINT = 8'd2;

  localparam logic              RST_QUANT_MODE = 1'b1;
  localparam logic [GAIN_W-1:0] RST_QUANT_GAIN = 24'd65536;
  localparam logic signed [7:0] RST_ZERO_POINT = -8'sd128;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [PIX_W-1:0]         chan_t;

  // truncate Q16 sum to integer, clamp to 0..255
  function automatic chan_t clamp_chan(input logic signed [SUM_W-1:0] s);
    chan_t c;
    if (s[SUM_W-1]) begin
      c = '0;
    end else if (s[SUM_W-2:24] != '0) begin
      c = '1;
    end else begin
      c = s[23:16];
    end
    return c;
  endfunction

  // trunc toward zero of t/65536, saturated to int8
  function automatic logic [7:0] quant_sat(input logic signed [BIAS_W-1:0] t);
    logic signed [BIAS_W-1:0] tb;
    logic signed [QSH_W-1:0]  q;
    logic [7:0]               r;
    tb = t + (t[BIAS_W-1] ? BIAS_W'(65535) : BIAS_W'(0));
    q  = tb[BIAS_W-1:16];
    if (q > QSH_W'(127)) begin
      r = 8'h7f;
    end else if (q < -QSH_W'(128)) begin
      r = 8'h80;
    end else begin
      r = q[7:0];
    end
    return r;
  endfunction

endpackage

@@ src/y2rq_if.sv @@
interface y2rq_pix_if;
  logic                       valid;
  logic                       ready;
  logic [y2rq_pkg::PIX_W-1:0] luma;
  logic [y2rq_pkg::PIX_W-1:0] chroma_blue;
  logic [y2rq_pkg::PIX_W-1:0] chroma_red;
  modport source (output valid, luma, chroma_blue, chroma_red, input ready);
  modport sink   (input valid, luma, chroma_blue, chroma_red, output ready);
endinterface

interface y2rq_rgb_if;
  logic                        valid;
  logic                        ready;
  logic signed [7:0]           red_quant;
  logic signed [7:0]           green_quant;
  logic signed [7:0]           blue_quant;
  logic [y2rq_pkg::NORM_W-1:0] red_norm;
  logic [y2rq_pkg::NORM_W-1:0] green_norm;
  logic [y2rq_pkg::NORM_W-1:0] blue_norm;
  modport source (output valid, red_quant, green_quant, blue_quant,
                  red_norm, green_norm, blue_norm, input ready);
  modport sink   (input valid, red_quant, green_quant, blue_quant,
                  red_norm, green_norm, blue_norm, output ready);
endinterface

interface y2rq_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [y2rq_pkg::CFG_IDX_W-1:0]  index;
  logic [y2rq_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/yuv_to_rgb_quantizer.sv @@
// YUV to RGB converter (full-range BT.601, Q16) with int8 quantization or
// Q0.16 normalized output. Four-stage pipeline: coefficient products,
// channel sums with clamp, gain multiply, zero-point add with saturation.
// One pixel per clock sustained while out ready is high; each stage holds
// its word under backpressure and takes a new one as soon as it frees up.
// Configuration writes are taken every cycle (cfg ready is always high)
// and must be done while no pixel is in flight. Register 0 selects
// quantized (1) or normalized (0) mode, register 1 is the 24-bit Q16 gain,
// register 2 the signed zero point; other indexes are ignored.
module yuv_to_rgb_quantizer (
  input  logic        clk,
  input  logic        rst_n,
  y2rq_pix_if.sink    in_if,
  y2rq_rgb_if.source  out_if,
  y2rq_cfg_if.sink    cfg_if
);

  // configuration
  logic                              quant_mode_r;
  logic [y2rq_pkg::GAIN_W-1:0]       quant_gain_r;
  logic signed [7:0]                 zero_point_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quant_mode_r <= y2rq_pkg::RST_QUANT_MODE;
      quant_gain_r <= y2rq_pkg::RST_QUANT_GAIN;
      zero_point_r <= y2rq_pkg::RST_ZERO_POINT;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        y2rq_pkg::REG_QUANT_MODE: quant_mode_r <= cfg_if.data[0];
        y2rq_pkg::REG_QUANT_GAIN: quant_gain_r <= cfg_if.data[y2rq_pkg::GAIN_W-1:0];
        y2rq_pkg::REG_ZERO_POINT: zero_point_r <= $signed(cfg_if.data[7:0]);
        default: ;
      endcase
    end
  end

  // stage valids and ready chain
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_r || out_if.ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_if.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_if.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // stage 1: coefficient products
  logic signed [8:0]   u_s, v_s;
  y2rq_pkg::chan_t     y1_r;
  y2rq_pkg::prod_t     prv_r, pgu_r, pgv_r, pbu_r;

  assign u_s = $signed({1'b0, in_if.chroma_blue}) - 9'sd128;
  assign v_s = $signed({1'b0, in_if.chroma_red}) - 9'sd128;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      y1_r  <= in_if.luma;
      prv_r <= y2rq_pkg::COEF_RV * v_s;
      pgu_r <= y2rq_pkg::COEF_GU * u_s;
      pgv_r <= y2rq_pkg::COEF_GV * v_s;
      pbu_r <= y2rq_pkg::COEF_BU * u_s;
    end
  end

  // stage 2: sums and clamp
  logic signed [y2rq_pkg::SUM_W-1:0] ysh, sum_r_c, sum_g_c, sum_b_c;
  y2rq_pkg::chan_t                   ch2_r [3];

  assign ysh     = $signed({4'b0, y1_r, 16'b0});
  assign sum_r_c = ysh + y2rq_pkg::SUM_W'(prv_r);
  assign sum_g_c = ysh - y2rq_pkg::SUM_W'(pgu_r) - y2rq_pkg::SUM_W'(pgv_r);
  assign sum_b_c = ysh + y2rq_pkg::SUM_W'(pbu_r);

  always_ff @(posedge clk) begin
    if (rdy2) begin
      ch2_r[0] <= y2rq_pkg::clamp_chan(sum_r_c);
      ch2_r[1] <= y2rq_pkg::clamp_chan(sum_g_c);
      ch2_r[2] <= y2rq_pkg::clamp_chan(sum_b_c);
    end
  end

  // stage 3: gain multiply
  logic [y2rq_pkg::SCL_W-1:0] scl3_r [3];
  y2rq_pkg::chan_t            ch3_r  [3];

  always_ff @(posedge clk) begin
    if (rdy3) begin
      for (int k = 0; k < 3; k++) begin
        scl3_r[k] <= y2rq_pkg::SCL_W'(ch2_r[k]) * y2rq_pkg::SCL_W'(quant_gain_r);
        ch3_r[k]  <= ch2_r[k];
      end
    end
  end

  // stage 4: zero point, saturation, mode select
  logic signed [y2rq_pkg::BIAS_W-1:0] zp_q16;
  logic [7:0]                         q4_r [3];
  logic [y2rq_pkg::NORM_W-1:0]        n4_r [3];

  assign zp_q16 = $signed({{10{zero_point_r[7]}}, zero_point_r, 16'b0});

  always_ff @(posedge clk) begin
    if (rdy4) begin
      for (int k = 0; k < 3; k++) begin
        q4_r[k] <= quant_mode_r
                 ? y2rq_pkg::quant_sat($signed({2'b0, scl3_r[k]}) + zp_q16) : 8'h00;
        n4_r[k] <= quant_mode_r ? '0 : {ch3_r[k], ch3_r[k]};
      end
    end
  end

  assign out_if.valid       = v4_r;
  assign out_if.red_quant   = $signed(q4_r[0]);
  assign out_if.green_quant = $signed(q4_r[1]);
  assign out_if.blue_quant  = $signed(q4_r[2]);
  assign out_if.red_norm    = n4_r[0];
  assign out_if.green_norm  = n4_r[1];
  assign out_if.blue_norm   = n4_r[2];

`ifndef SYNTHESIS
  a_norm_zero_in_quant: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && quant_mode_r |->
      out_if.red_norm == '0 && out_if.green_norm == '0 && out_if.blue_norm == '0)
    else $error("normalized fields not zero in quantized mode");

  a_quant_zero_in_norm: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !quant_mode_r |->
      out_if.red_quant == 8'sd0 && out_if.green_quant == 8'sd0 &&
      out_if.blue_quant == 8'sd0)
    else $error("quantized fields not zero in normalized mode");

  a_norm_byte_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !quant_mode_r |->
      out_if.red_norm[15:8] == out_if.red_norm[7:0] &&
      out_if.green_norm[15:8] == out_if.green_norm[7:0] &&
      out_if.blue_norm[15:8] == out_if.blue_norm[7:0])
    else $error("normalized value is not channel times 257");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> v1_r && v2_r && v3_r && v4_r && !out_if.ready)
    else $error("input stalled with a free pipeline slot");
`endif

endmodule

@@ verif/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_WORDS   = 150;

  localparam longint Q16_RV = 91881;
  localparam longint Q16_GU = 22554;
  localparam longint Q16_GV = 46802;
  localparam longint Q16_BU = 116130;

  // indexes outside the register map, writes must be dropped
  localparam logic [y2rq_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = 8'd3;
  localparam logic [y2rq_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = 8'hff;

  typedef struct packed {
    logic [y2rq_pkg::PIX_W-1:0] luma;
    logic [y2rq_pkg::PIX_W-1:0] chroma_blue;
    logic [y2rq_pkg::PIX_W-1:0] chroma_red;
  } pix_word_t;

  typedef struct packed {
    logic signed [7:0]           red_quant;
    logic signed [7:0]           green_quant;
    logic signed [7:0]           blue_quant;
    logic [y2rq_pkg::NORM_W-1:0] red_norm;
    logic [y2rq_pkg::NORM_W-1:0] green_norm;
    logic [y2rq_pkg::NORM_W-1:0] blue_norm;
  } rgb_word_t;

  logic clk;
  logic rst_n;

  y2rq_pix_if pix ();
  y2rq_rgb_if rgb ();
  y2rq_cfg_if cfg ();

  yuv_to_rgb_quantizer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (pix),
    .out_if (rgb),
    .cfg_if (cfg)
  );

  // shadow of the converter's registers
  logic                        mode_quant;
  logic [y2rq_pkg::GAIN_W-1:0] gain_q16;
  logic signed [7:0]           zero_pt;

  pix_word_t   pixel_pending_q[$];
  rgb_word_t   rgb_due_q[$];
  int unsigned errors;
  int unsigned n_checked;
  bit          tx_idle_en;
  bit          rx_idle_en;
  int unsigned tx_gap;
  int unsigned rx_gap;
  int unsigned hold_left;
  bit [1:0]    hold_done;
  pix_word_t   tx_word;
  rgb_word_t   rx_due;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [y2rq_pkg::PIX_W-1:0] pick_sample();
    logic [y2rq_pkg::PIX_W-1:0] corner[6];
    corner = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
    if ($urandom_range(0, 9) < 7) return y2rq_pkg::PIX_W'($urandom());
    return corner[$urandom_range(0, 5)];
  endfunction

  function automatic rgb_word_t convert_pixel(input logic [y2rq_pkg::PIX_W-1:0] y8,
                                              input logic [y2rq_pkg::PIX_W-1:0] cb8,
                                              input logic [y2rq_pkg::PIX_W-1:0] cr8);
    longint    y, u, v, t, q;
    longint    s[3];
    longint    c[3];
    logic [7:0]  qv[3];
    logic [15:0] nv[3];
    rgb_word_t r;
    y = longint'(y8);
    u = longint'(cb8) - 128;
    v = longint'(cr8) - 128;
    s[0] = y * 65536 + Q16_RV * v;
    s[1] = y * 65536 - Q16_GU * u - Q16_GV * v;
    s[2] = y * 65536 + Q16_BU * u;
    for (int k = 0; k < 3; k++) begin
      if (s[k] < 0) c[k] = 0;
      else c[k] = (s[k] >>> 16) > 255 ? 255 : (s[k] >>> 16);
      qv[k] = '0;
      nv[k] = '0;
      if (mode_quant) begin
        t = c[k] * longint'(gain_q16) + longint'(zero_pt) * 65536;
        q = (t < 0) ? -((-t) >>> 16) : (t >>> 16);
        if (q > 127) q = 127;
        if (q < -128) q = -128;
        qv[k] = q[7:0];
      end else begin
        nv[k] = 16'(c[k] * 257);
      end
    end
    r.red_quant   = qv[0];
    r.green_quant = qv[1];
    r.blue_quant  = qv[2];
    r.red_norm    = nv[0];
    r.green_norm  = nv[1];
    r.blue_norm   = nv[2];
    return r;
  endfunction

  // pixel driver
  always @(posedge clk) begin
    if (!rst_n) begin
      pix.valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (pix.valid && pix.ready) begin
        rgb_due_q.push_back(convert_pixel(pix.luma, pix.chroma_blue, pix.chroma_red));
      end
      if (!pix.valid || pix.ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          pix.valid <= 1'b0;
        end else if (pixel_pending_q.size() == 0) begin
          pix.valid <= 1'b0;
        end else begin
          tx_word = pixel_pending_q.pop_front();
          pix.valid       <= 1'b1;
          pix.luma        <= tx_word.luma;
          pix.chroma_blue <= tx_word.chroma_blue;
          pix.chroma_red  <= tx_word.chroma_red;
          if (tx_idle_en) tx_gap = pick_gap();
        end
      end
    end
  end

  task automatic cmp_field(input string name, input logic [15:0] exp_v,
                           input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // rgb monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      rgb.ready <= 1'b0;
      rx_gap = 0;
      hold_left = 0;
    end else begin
      if (rgb.valid && rgb.ready) begin
        if (rgb_due_q.size() == 0) begin
          $display("%0t: rgb word with no pixel pending, got %h %h %h %h %h %h", $time,
                   rgb.red_quant, rgb.green_quant, rgb.blue_quant,
                   rgb.red_norm, rgb.green_norm, rgb.blue_norm);
          errors++;
        end else begin
          rx_due = rgb_due_q.pop_front();
          cmp_field("red_quant",   rx_due.red_quant,   rgb.red_quant);
          cmp_field("green_quant", rx_due.green_quant, rgb.green_quant);
          cmp_field("blue_quant",  rx_due.blue_quant,  rgb.blue_quant);
          cmp_field("red_norm",    rx_due.red_norm,    rgb.red_norm);
          cmp_field("green_norm",  rx_due.green_norm,  rgb.green_norm);
          cmp_field("blue_norm",   rx_due.blue_norm,   rgb.blue_norm);
          n_checked++;
        end
      end
      // long hold-offs while the driver keeps pushing, to back up the pipeline
      if (hold_left > 0) begin
        hold_left--;
        rgb.ready <= 1'b0;
      end else if (!hold_done[0] && n_checked >= 300) begin
        hold_done[0] = 1'b1;
        hold_left = 400;
        rgb.ready <= 1'b0;
      end else if (!hold_done[1] && n_checked >= 700) begin
        hold_done[1] = 1'b1;
        hold_left = 250;
        rgb.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        rgb.ready <= 1'b0;
      end else begin
        rgb.ready <= 1'b1;
        if (rx_idle_en) rx_gap = pick_gap();
      end
    end
  end

  task automatic cfg_write(input logic [y2rq_pkg::CFG_IDX_W-1:0] idx,
                           input logic [y2rq_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      y2rq_pkg::REG_QUANT_MODE: mode_quant = data[0];
      y2rq_pkg::REG_QUANT_GAIN: gain_q16   = data[y2rq_pkg::GAIN_W-1:0];
      y2rq_pkg::REG_ZERO_POINT: zero_pt    = data[7:0];
      default: ;
    endcase
  endtask

  task automatic push_pixel(input logic [7:0] y, input logic [7:0] cb,
                            input logic [7:0] cr);
    pix_word_t w;
    w.luma        = y;
    w.chroma_blue = cb;
    w.chroma_red  = cr;
    pixel_pending_q.push_back(w);
  endtask

  // wait until the pipeline is empty
  task automatic drain();
    while (pixel_pending_q.size() != 0 || pix.valid || rgb_due_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_directed();
    push_pixel(8'd0,   8'd0,   8'd0);
    push_pixel(8'd255, 8'd255, 8'd255);
    push_pixel(8'd0,   8'd128, 8'd128);
    push_pixel(8'd255, 8'd128, 8'd128);
    push_pixel(8'd128, 8'd128, 8'd128);
    push_pixel(8'd0,   8'd128, 8'd0);    // red below zero
    push_pixel(8'd255, 8'd128, 8'd255);  // red above 255
    push_pixel(8'd0,   8'd255, 8'd128);  // green below zero
    push_pixel(8'd255, 8'd0,   8'd0);    // green above 255
    push_pixel(8'd0,   8'd0,   8'd255);
    push_pixel(8'd76,  8'd84,  8'd255);
    push_pixel(8'd149, 8'd43,  8'd21);
    drain();
  endtask

  task automatic run_phase(input int unsigned n, input bit tx_idle, input bit rx_idle);
    pix_word_t w;
    tx_idle_en <= tx_idle;
    rx_idle_en <= rx_idle;
    repeat (n) begin
      w.luma        = pick_sample();
      w.chroma_blue = pick_sample();
      w.chroma_red  = pick_sample();
      pixel_pending_q.push_back(w);
    end
    drain();
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    logic [y2rq_pkg::GAIN_W-1:0] g;
    rst_n           = 1'b0;
    pix.valid       = 1'b0;
    pix.luma        = '0;
    pix.chroma_blue = '0;
    pix.chroma_red  = '0;
    rgb.ready       = 1'b0;
    cfg.valid       = 1'b0;
    cfg.index       = '0;
    cfg.data        = '0;
    mode_quant      = y2rq_pkg::RST_QUANT_MODE;
    gain_q16        = y2rq_pkg::RST_QUANT_GAIN;
    zero_pt         = y2rq_pkg::RST_ZERO_POINT;
    errors          = 0;
    n_checked       = 0;
    hold_done       = '0;
    tx_idle_en      = 1'b1;
    rx_idle_en      = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    run_directed();

    cfg_write(y2rq_pkg::REG_QUANT_MODE, 24'hfffffe);
    cfg_write(REG_UNMAPPED_LO, 24'hffffff);
    cfg_write(REG_UNMAPPED_HI, 24'h000000);
    run_directed();

    cfg_write(y2rq_pkg::REG_QUANT_MODE, 24'h000001);
    cfg_write(y2rq_pkg::REG_QUANT_GAIN, 24'h000000);
    cfg_write(y2rq_pkg::REG_ZERO_POINT, 24'habcd7f);
    run_phase(PHASE_WORDS, 1'b1, 1'b1);

    cfg_write(y2rq_pkg::REG_QUANT_GAIN, 24'hffffff);
    cfg_write(y2rq_pkg::REG_ZERO_POINT, 24'h000080);
    run_phase(PHASE_WORDS, 1'b0, 1'b0);

    cfg_write(y2rq_pkg::REG_QUANT_MODE, 24'h000000);
    cfg_write(REG_UNMAPPED_LO, 24'h000001);
    run_phase(PHASE_WORDS, 1'b1, 1'b1);

    for (int p = 0; p < 3; p++) begin
      if ($urandom_range(0, 3) == 0) g = y2rq_pkg::GAIN_W'($urandom());
      else g = y2rq_pkg::GAIN_W'($urandom_range(16000, 140000));
      cfg_write(y2rq_pkg::REG_QUANT_MODE, {23'($urandom()), 1'b1});
      cfg_write(y2rq_pkg::REG_QUANT_GAIN, g);
      cfg_write(y2rq_pkg::REG_ZERO_POINT, {16'($urandom()), 8'($urandom())});
      if (p == 0) begin
        run_phase(PHASE_WORDS / 2, 1'b1, 1'b0);
        run_phase(PHASE_WORDS / 2, 1'b0, 1'b1);
      end else begin
        run_phase(PHASE_WORDS, p[0], 1'b1);
      end
    end

    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
